@@ rtl/ddlsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ddlsf_pkg: shared definitions for the door drive limit-switch mode machine
// Mode codes, field widths, register map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ddlsf_pkg;

  // door mode vector
  localparam int MODE_BITS = 4;
  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t M_INIT    = 4'd0;
  localparam mode_t M_UNKNOWN = 4'd1;
  localparam mode_t M_CLOSED  = 4'd2;
  localparam mode_t M_NEG     = 4'd3;
  localparam mode_t M_ACCNEG  = 4'd4;
  localparam mode_t M_DECNEG  = 4'd5;
  localparam mode_t M_OPEN    = 4'd6;
  localparam mode_t M_POS     = 4'd7;
  localparam mode_t M_ACCPOS  = 4'd8;
  localparam mode_t M_DECPOS  = 4'd9;

  // switch levels, switch_one in bit 0 up to switch_four in bit 3
  localparam int SW_BITS = 4;
  typedef logic [SW_BITS-1:0] sw_t;

  // input transfer: four switches and the direction bit, padded to a byte
  localparam int IN_BITS = 8;

  // speed magnitude registers
  localparam int MAG_BITS = 15;
  typedef logic [MAG_BITS-1:0] mag_t;

  localparam mag_t SLOW_RESET = 15'd250;
  localparam mag_t FAST_RESET = 15'd800;

  // register index, taken from paddr[2]
  localparam logic REG_SLOW = 1'b0;
  localparam logic REG_FAST = 1'b1;

endpackage

`default_nettype wire

@@ rtl/door_drive_limit_switch_fsm_core.sv @@
// ----------------------------------------------------------------------------
// door_drive_limit_switch_fsm_core: door drive limit-switch mode machine
// Tracks the door position from switch toggles and issues the drive speed.
// ----------------------------------------------------------------------------
// The mode/speed feedback loop is a single registered step, so one scan is
// taken per clock while s_tready is high. The mode, previous switch levels
// and speed update at the edge that takes the scan; its result (speed and
// mode) goes at that edge into the result register, or into the skid
// register while a result waits; the output stage is two-deep (result and
// skid register). Speed magnitudes come from two APB registers (slow at 0x0,
// fast at 0x4) and saturate to the largest positive SPEED_BITS value.
`default_nettype none

module door_drive_limit_switch_fsm_core
  import ddlsf_pkg::*;
#(
  parameter int SPEED_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // scan input; tdata: switch_one, switch_two, switch_three, switch_four,
  // move_dir, then zero padding
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [IN_BITS-1:0]   s_tdata,
  // result output; tdata: drive_speed (SPEED_BITS, signed), door_mode (4),
  // then zero padding
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [((SPEED_BITS+MODE_BITS+7)/8)*8-1:0] m_tdata,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int OUT_BITS = ((SPEED_BITS + MODE_BITS + 7) / 8) * 8;
  localparam logic [31:0] MAXPOS = (32'd1 << (SPEED_BITS - 1)) - 32'd1;

  typedef logic signed [SPEED_BITS-1:0] speed_t;

  // configuration registers
  mag_t slow_speed;
  mag_t fast_speed;

  // mode state
  mode_t  mode;
  mode_t  mode_next;
  sw_t    prev_switches;
  speed_t speed;
  speed_t speed_next;

  // output stage
  logic    out_valid;
  mode_t   out_mode;
  speed_t  out_speed;
  logic    skid_valid;
  mode_t   skid_mode;
  speed_t  skid_speed;

  logic    accept;
  logic    pop;
  sw_t     sw;
  sw_t     tog;
  logic    open_dir;
  speed_t  slow_pos;
  speed_t  slow_neg;
  speed_t  fast_pos;
  speed_t  fast_neg;

  // saturate a 15-bit magnitude to the positive range of the speed word
  function automatic speed_t sat_mag(input mag_t mag);
    logic [31:0] m32;
    logic [31:0] s32;
    m32 = {17'd0, mag};
    s32 = (m32 > MAXPOS) ? MAXPOS : m32;
    return speed_t'(s32[SPEED_BITS-1:0]);
  endfunction

  // APB register access
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_speed <= SLOW_RESET;
      fast_speed <= FAST_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SLOW: slow_speed <= pwdata[MAG_BITS-1:0];
        REG_FAST: fast_speed <= pwdata[MAG_BITS-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOW: prdata = {17'd0, slow_speed};
      REG_FAST: prdata = {17'd0, fast_speed};
      default:  prdata = 32'd0;
    endcase
  end

  // scan decode and signed speed values
  assign sw       = s_tdata[SW_BITS-1:0];
  assign open_dir = s_tdata[SW_BITS];
  assign tog      = sw ^ prev_switches;

  assign slow_pos = sat_mag(slow_speed);
  assign fast_pos = sat_mag(fast_speed);
  assign slow_neg = -slow_pos;
  assign fast_neg = -fast_pos;

  // next mode and speed; later checks override earlier ones
  always_comb begin
    mode_next  = mode;
    speed_next = speed;
    unique case (mode)
      M_INIT: begin
        if (sw == '0) mode_next = M_UNKNOWN;
      end
      M_UNKNOWN: begin
        if (!open_dir && tog[0]) mode_next = M_CLOSED;
        if (open_dir  && tog[0]) mode_next = M_NEG;
        if (open_dir  && tog[1]) mode_next = M_ACCNEG;
        if (open_dir  && tog[2]) mode_next = M_DECNEG;
        if (open_dir  && tog[3]) mode_next = M_OPEN;
        if (!open_dir && tog[3]) mode_next = M_POS;
        if (!open_dir && tog[2]) mode_next = M_ACCPOS;
        if (!open_dir && tog[1]) mode_next = M_DECPOS;
      end
      M_CLOSED: begin
        speed_next = '0;
        if (open_dir) mode_next = M_NEG;
      end
      M_NEG: begin
        speed_next = slow_neg;
        if (open_dir && tog[1]) mode_next = M_ACCNEG;
        if (!open_dir)          mode_next = M_DECPOS;
      end
      M_ACCNEG: begin
        speed_next = fast_neg;
        if (open_dir && tog[2]) mode_next = M_DECNEG;
        if (!open_dir)          mode_next = M_ACCPOS;
      end
      M_DECNEG: begin
        speed_next = slow_neg;
        if (open_dir && tog[3]) mode_next = M_OPEN;
        if (!open_dir)          mode_next = M_POS;
      end
      M_OPEN: begin
        speed_next = '0;
        if (!open_dir) mode_next = M_POS;
      end
      M_POS: begin
        speed_next = slow_pos;
        if (!open_dir && tog[2]) mode_next = M_ACCPOS;
        if (open_dir)            mode_next = M_DECNEG;
      end
      M_ACCPOS: begin
        speed_next = fast_pos;
        if (!open_dir && tog[1]) mode_next = M_DECPOS;
        if (open_dir)            mode_next = M_ACCNEG;
      end
      M_DECPOS: begin
        speed_next = slow_pos;
        if (!open_dir && tog[0]) mode_next = M_CLOSED;
        if (open_dir)            mode_next = M_NEG;
      end
      default: ;
    endcase
  end

  // handshakes
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  // state update on every accepted scan
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_INIT;
      prev_switches <= '0;
      speed         <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      prev_switches <= sw;
      speed         <= speed_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_mode  <= skid_mode;
        out_speed <= skid_speed;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_mode  <= mode_next;
        out_speed <= speed_next;
      end else begin
        skid_mode  <= mode_next;
        skid_speed <= speed_next;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_BITS'({out_mode, out_speed});

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while result register empty");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode <= M_DECPOS)
    else $error("door mode beyond last code");

  a_end_stop: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == M_CLOSED || mode == M_OPEN)) |=> (speed == '0))
    else $error("speed not zero after a scan at an end position");

  a_init_exit: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == M_INIT) |=> (mode == M_INIT || mode == M_UNKNOWN))
    else $error("init left for a mode other than unknown");

endmodule

`default_nettype wire
